// File: hw/rtl/dcs_pkg.sv
// package: payload types, sizes and controller/datapath interface types
package dcs_pkg;

  localparam int MAX_CIRCLES = 8;
  localparam int COORD_BITS  = 10;
  localparam int SLOT_W      = 3;
  localparam int XY_W        = 10;
  localparam int RAD_W       = 9;
  localparam int GRAY_W      = 8;
  localparam int ACC_W       = 28;
  localparam int CNT_W       = SLOT_W + 1;
  localparam int SQ_W        = 2 * XY_W;
  localparam int RSQ_W       = 2 * RAD_W;

  localparam logic [XY_W-1:0]  COORD_MASK = XY_W'((1 << COORD_BITS) - 1);
  localparam logic [ACC_W-1:0] ACC_MAX    = {ACC_W{1'b1}};

  localparam logic KIND_CIRCLE = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [XY_W-1:0]   center_x_in;
    logic [XY_W-1:0]   center_y_in;
    logic [RAD_W-1:0]  radius_in;
    logic [XY_W-1:0]   pixel_x;
    logic [XY_W-1:0]   pixel_y;
    logic [GRAY_W-1:0] gray;
    logic              last_pixel;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] best_slot;
    logic [XY_W-1:0]   best_center_x;
    logic [XY_W-1:0]   best_center_y;
    logic [RAD_W-1:0]  best_radius;
    logic [ACC_W-1:0]  best_sum;
  } out_item_t;

  typedef struct packed {
    logic              load_circle;
    logic              load_pixel;
    logic              clear_best;
    logic              diff;
    logic              square;
    logic              accum;
    logic              search;
    logic [SLOT_W-1:0] idx;
  } dcs_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } dcs_stat_t;

endpackage

// File: hw/rtl/darkest_circle_selector_core.sv
// top level: darkest circle selector, controller plus datapath
//
//  channel  | ports                     | beat taken when
//  ---------+---------------------------+---------------------------
//  input    | start, busy, in_data      | start high and busy low
//  result   | out_valid, out_data       | out_valid high, one cycle
//
// a circle beat is stored at once and busy stays low
// a pixel beat steps each loaded circle through the shared distance unit (diff, square, accumulate)
// a last pixel then runs the minimum search over the loaded circles and shows the
// result in the done state; with no circle loaded a last pixel goes straight to done
// synchronous reset clears the circle table, sums and count; no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle
module darkest_circle_selector_core import dcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  dcs_cmd_t  cmd;
  dcs_stat_t stat;

  dcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .kind       (in_data.kind),
    .last_pixel (in_data.last_pixel),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .emit       (out_valid)
  );

  dcs_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .best    (out_data)
  );

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a busy period");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind == KIND_PIXEL && !in_data.last_pixel) |=> !out_valid)
    else $error("result after a pixel that is not the last");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.best_sum == '0 && out_data.best_slot == '0))
    else $error("result without a circle carries data");

endmodule

// File: hw/rtl/dcs_ctrl.sv
// controller: sequences the per-slot test, accumulate and minimum search
module dcs_ctrl import dcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      kind,
  input  logic      last_pixel,
  input  dcs_stat_t stat,
  output dcs_cmd_t  cmd,
  output logic      busy,
  output logic      emit
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIFF = 6'b000010,
    ST_SQR  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_SRCH = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              last_r, last_nxt;
  logic              accept;
  logic              at_end;

  assign accept = start && (state_r == ST_IDLE);
  assign at_end = ({1'b0, idx_r} == (stat.count - CNT_W'(1)));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (kind == KIND_CIRCLE) begin
            cmd.load_circle = 1'b1;
          end else begin
            cmd.load_pixel = 1'b1;
            idx_nxt        = '0;
            last_nxt       = last_pixel;
            if (stat.count == '0) begin
              cmd.clear_best = 1'b1;
              if (last_pixel) state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_DIFF;
            end
          end
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        if (at_end) begin
          idx_nxt   = '0;
          state_nxt = last_r ? ST_SRCH : ST_IDLE;
        end else begin
          idx_nxt   = idx_r + SLOT_W'(1);
          state_nxt = ST_DIFF;
        end
      end
      ST_SRCH: begin
        cmd.search = 1'b1;
        if (at_end) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign emit = (state_r == ST_DONE);

endmodule

// File: hw/rtl/dcs_datapath.sv
// datapath: circle table, shared distance unit, sums and best-circle registers
module dcs_datapath import dcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dcs_cmd_t  cmd,
  output dcs_stat_t stat,
  output out_item_t best
);

  logic [XY_W-1:0]   cx_r  [MAX_CIRCLES];
  logic [XY_W-1:0]   cy_r  [MAX_CIRCLES];
  logic [RAD_W-1:0]  rad_r [MAX_CIRCLES];
  logic [ACC_W-1:0]  acc_r [MAX_CIRCLES];
  logic [CNT_W-1:0]  count_r;

  logic [XY_W-1:0]   px_r, py_r;
  logic [GRAY_W-1:0] gray_r;
  logic [XY_W-1:0]   adx_r, ady_r;
  logic [SQ_W-1:0]   dx2_r, dy2_r;
  logic [RSQ_W-1:0]  r2_r;
  logic [ACC_W-1:0]  idx_acc_r;
  out_item_t         best_r;

  logic              slot_ok;
  logic [XY_W:0]     dx, dy;
  logic [XY_W:0]     dx_neg, dy_neg;
  logic [SQ_W:0]     dist_sq;
  logic              hit;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_sat;
  logic              take;

  assign slot_ok = ({1'b0, in_data.slot} < CNT_W'(MAX_CIRCLES));

  assign dx     = {1'b0, px_r} - {1'b0, cx_r[cmd.idx]};
  assign dy     = {1'b0, py_r} - {1'b0, cy_r[cmd.idx]};
  assign dx_neg = -dx;
  assign dy_neg = -dy;

  assign dist_sq = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign hit     = (dist_sq < (SQ_W+1)'(r2_r));
  assign acc_sum = {1'b0, idx_acc_r} + (ACC_W+1)'(gray_r);
  assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

  assign take = (cmd.idx == '0) || (acc_r[cmd.idx] < best_r.best_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CIRCLES; i++) begin
        cx_r[i]  <= '0;
        cy_r[i]  <= '0;
        rad_r[i] <= '0;
        acc_r[i] <= '0;
      end
      count_r <= '0;
      best_r  <= '0;
    end else begin
      if (cmd.load_circle && slot_ok) begin
        cx_r[in_data.slot]  <= in_data.center_x_in & COORD_MASK;
        cy_r[in_data.slot]  <= in_data.center_y_in & COORD_MASK;
        rad_r[in_data.slot] <= in_data.radius_in;
        acc_r[in_data.slot] <= '0;
        count_r             <= {1'b0, in_data.slot} + CNT_W'(1);
      end
      if (cmd.accum && hit) begin
        acc_r[cmd.idx] <= acc_sat;
      end
      if (cmd.clear_best) begin
        best_r <= '0;
      end
      if (cmd.search && take) begin
        best_r.found         <= 1'b1;
        best_r.best_slot     <= cmd.idx;
        best_r.best_center_x <= cx_r[cmd.idx];
        best_r.best_center_y <= cy_r[cmd.idx];
        best_r.best_radius   <= rad_r[cmd.idx];
        best_r.best_sum      <= acc_r[cmd.idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      px_r   <= in_data.pixel_x & COORD_MASK;
      py_r   <= in_data.pixel_y & COORD_MASK;
      gray_r <= in_data.gray;
    end
    if (cmd.diff) begin
      adx_r <= dx[XY_W] ? dx_neg[XY_W-1:0] : dx[XY_W-1:0];
      ady_r <= dy[XY_W] ? dy_neg[XY_W-1:0] : dy[XY_W-1:0];
    end
    if (cmd.square) begin
      dx2_r     <= adx_r * adx_r;
      dy2_r     <= ady_r * ady_r;
      r2_r      <= rad_r[cmd.idx] * rad_r[cmd.idx];
      idx_acc_r <= acc_r[cmd.idx];
    end
  end

  assign stat.count = count_r;
  assign best       = best_r;

endmodule
